FILE: src/aabb_frustum_cull_test_defines.svh
// ----------------------------------------------------------------------------
// AABB frustum cull test assertion macros
// Concurrent assertion wrappers used by the cull test; they compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_TEST_DEFINES_SVH
`define AABB_FRUSTUM_CULL_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define AFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is active.
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/afc_pkg.sv
// ----------------------------------------------------------------------------
// AABB frustum cull test package
// Shared constants and the control word that travels along the plane cells.
// ----------------------------------------------------------------------------
package afc_pkg;

  // Plane register layout: three Q2.14 normal components and an offset.
  localparam int unsigned NORM_W      = 16;
  localparam int unsigned FRAC_BITS   = 14;
  localparam int unsigned PLANE_W     = 64;
  localparam int unsigned OFFSET_SLOT = 3;
  localparam int unsigned AXES        = 3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BASE = 3'd0;

  // Corner selectors within a box.
  localparam int unsigned CORNER_MIN = 0;
  localparam int unsigned CORNER_MAX = 1;

  // Control word passed from cell to cell.
  typedef struct packed {
    logic valid;
    logic unculled;
  } afc_ctl_t;

endpackage

FILE: src/aabb_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// AABB frustum cull test
// Tests one axis-aligned box per cycle against PLANE_COUNT frustum planes
// (six by default) using the positive-vertex method, one pipelined cell per plane.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  --------  ---------------------------------------  --------------------------
//  input     in_min_x/y/z, in_max_x/y/z               start high, busy low
//  result    out_inside_res                           out_valid strobe, 1 cycle
//  config    cfg_index, cfg_data                      cfg_we, immediate write
//
// One box is accepted every cycle outside reset; each result passes through the
// multiply register and then the sum register of each plane cell in turn.
// Reset is synchronous and clears the plane registers and the pipeline flags.
// busy is high only while reset is held. The receiver cannot stall, so
// results leave on out_valid in the same order the boxes entered.
`include "aabb_frustum_cull_test_defines.svh"

module aabb_frustum_cull_test #(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      in_min_x,
  input  logic signed [COORD_BITS-1:0]      in_min_y,
  input  logic signed [COORD_BITS-1:0]      in_min_z,
  input  logic signed [COORD_BITS-1:0]      in_max_x,
  input  logic signed [COORD_BITS-1:0]      in_max_y,
  input  logic signed [COORD_BITS-1:0]      in_max_z,
  output logic                              out_valid,
  output logic                              out_inside_res,
  input  logic                              cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afc_pkg::PLANE_W-1:0]       cfg_data
);

  localparam int unsigned LATENCY = 2 * PLANE_COUNT;

  afc_pkg::afc_ctl_t                        ctl_chain [PLANE_COUNT+1];
  logic [PLANE_COUNT:0][1:0][2:0][COORD_BITS-1:0] box_chain;
  logic [PLANE_COUNT-1:0]                   plane_we;
  logic                                     accept;

  // The pipeline takes a box in every cycle outside reset.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Head of the chain: the new box, assumed inside until a plane rejects it.
  assign ctl_chain[0].valid    = accept;
  assign ctl_chain[0].unculled = 1'b1;
  assign box_chain[0][afc_pkg::CORNER_MIN] = {in_min_z, in_min_y, in_min_x};
  assign box_chain[0][afc_pkg::CORNER_MAX] = {in_max_z, in_max_y, in_max_x};

  // One cell per plane; each takes the configuration write for its index.
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    assign plane_we[g] = cfg_we &&
        (cfg_index == afc_pkg::REG_PLANE_BASE + afc_pkg::CFG_IDX_W'(g));

    afc_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .plane_we   (plane_we[g]),
      .plane_data (cfg_data),
      .ctl_i      (ctl_chain[g]),
      .box_i      (box_chain[g]),
      .ctl_o      (ctl_chain[g+1]),
      .box_o      (box_chain[g+1])
    );
  end

  // Result strobe and flag straight from the last cell's registers.
  assign out_valid      = ctl_chain[PLANE_COUNT].valid;
  assign out_inside_res = ctl_chain[PLANE_COUNT].unculled;

  // Every accepted box yields exactly one result, once it has passed all plane cells.
  `AFC_ASSERT_IMPL(a_latency, clk, rst_n, 1'b1, out_valid == $past(accept, LATENCY))

  // A box can only stay inside in a cell if it was inside in the cell before.
  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_chk
    `AFC_ASSERT_IMPL(a_inside_mono, clk, rst_n, ctl_chain[k+1].valid && ctl_chain[k+1].unculled, $past(ctl_chain[k].unculled, 2))
  end

  // A configuration write to the base index lands in the first plane cell.
  `AFC_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_we && (cfg_index == afc_pkg::REG_PLANE_BASE), g_cell[0].u_cell.plane_r == $past(cfg_data))

endmodule

FILE: src/afc_cell.sv
// ----------------------------------------------------------------------------
// AABB frustum cull plane cell
// Holds one plane, tests the box arriving from its neighbor against it and
// hands the box and the updated inside flag on through its stage registers.
// ----------------------------------------------------------------------------
module afc_cell #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 plane_we,
  input  logic [afc_pkg::PLANE_W-1:0]          plane_data,
  input  afc_pkg::afc_ctl_t                    ctl_i,
  input  logic [1:0][2:0][COORD_BITS-1:0]      box_i,
  output afc_pkg::afc_ctl_t                    ctl_o,
  output logic [1:0][2:0][COORD_BITS-1:0]      box_o
);

  localparam int unsigned PROD_W = afc_pkg::NORM_W + COORD_BITS;
  localparam int unsigned OFF_W  = afc_pkg::NORM_W + afc_pkg::FRAC_BITS;
  localparam int unsigned SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;

  logic [afc_pkg::PLANE_W-1:0]           plane_r;
  logic signed [afc_pkg::NORM_W-1:0]     norm   [afc_pkg::AXES];
  logic signed [COORD_BITS-1:0]          pick   [afc_pkg::AXES];
  logic signed [PROD_W-1:0]              prod_nxt [afc_pkg::AXES];
  logic signed [PROD_W-1:0]              prod_r   [afc_pkg::AXES];
  logic signed [afc_pkg::NORM_W-1:0]     offset;
  logic signed [SUM_W-1:0]               offset_ext;
  logic signed [SUM_W-1:0]               dist_sum;
  afc_pkg::afc_ctl_t                     ctl_a_r;
  afc_pkg::afc_ctl_t                     ctl_b_r;
  afc_pkg::afc_ctl_t                     ctl_b_nxt;
  logic [1:0][2:0][COORD_BITS-1:0]       box_a_r;
  logic [1:0][2:0][COORD_BITS-1:0]       box_b_r;

  // Plane register, loaded from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (plane_we) begin
      plane_r <= plane_data;
    end
  end

  // First stage: pick the positive vertex per axis and multiply by the normal.
  always_comb begin
    for (int a = 0; a < afc_pkg::AXES; a++) begin
      norm[a] = $signed(plane_r[a*afc_pkg::NORM_W +: afc_pkg::NORM_W]);
      pick[a] = norm[a][afc_pkg::NORM_W-1] ? $signed(box_i[afc_pkg::CORNER_MIN][a])
                                           : $signed(box_i[afc_pkg::CORNER_MAX][a]);
      prod_nxt[a] = norm[a] * pick[a];
    end
  end

  // Second stage: add the scaled offset and check the sign of the distance.
  always_comb begin
    offset     = $signed(plane_r[afc_pkg::OFFSET_SLOT*afc_pkg::NORM_W +: afc_pkg::NORM_W]);
    offset_ext = $signed({{(SUM_W-OFF_W){offset[afc_pkg::NORM_W-1]}}, offset,
                          {afc_pkg::FRAC_BITS{1'b0}}});
    dist_sum   = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + offset_ext;
    ctl_b_nxt.valid    = ctl_a_r.valid;
    ctl_b_nxt.unculled = ctl_a_r.unculled & ~dist_sum[SUM_W-1];
  end

  // Control registers of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_b_nxt;
    end
  end

  // Payload registers: products and the box travelling alongside.
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    box_a_r <= box_i;
    box_b_r <= box_a_r;
  end

  assign ctl_o = ctl_b_r;
  assign box_o = box_b_r;

endmodule
